// ===== src/hto_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy map package
// Shared types, field widths, codes and geometry of the tile occupancy map.
// ----------------------------------------------------------------------------
package hto_pkg;

    // Image geometry.
    localparam int IMAGE_SIZE = 1024;
    localparam int FINE_CELL  = 16;
    localparam int FINE_SHIFT = $clog2(FINE_CELL);
    localparam int CELLS      = IMAGE_SIZE / FINE_CELL;

    // Field widths.
    localparam int MODE_W  = 2;
    localparam int PIX_W   = 10;
    localparam int LEVEL_W = 8;
    localparam int CELL_W  = 6;
    localparam int CLASS_W = 2;

    // One memory word holds the flags of one 4x4 block of fine cells.
    localparam int BLOCK_SPAN = 4;
    localparam int SUB_W      = $clog2(BLOCK_SPAN);
    localparam int WORD_W     = BLOCK_SPAN * BLOCK_SPAN;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int BLK_W      = CELL_W - SUB_W;
    localparam int ADDR_W     = 2 * BLK_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] ALPHA_SOLID = 8'hFF;

    // Item kinds.
    localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Cell classes.
    localparam logic [CLASS_W-1:0] CLASS_EMPTY = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SOLID = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_F16   = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_F32   = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic              clr;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [BIT_W-1:0]  bit_idx;
    } t_store_req;

endpackage

// ===== src/hierarchical_tile_occupancy_map_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical tile occupancy map
// Three-level occupancy map over a 1024x1024 height map in 16x16 cells.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock of any kind: pixel samples, cell
// queries and clears all enter back to back at full rate. A pixel with nonzero
// red and full alpha marks its cell solid in the same cycle, a clear empties
// the whole map at once (each 4x4 block word carries its own valid bit), so
// neither needs a sweep after reset. A query's 4x4 block word is read from the
// flag memory into a register and then classified into the output register.
// The rate is set by the single flag memory, which serves one access per item;
// output backpressure stalls the input only once the two stages are full.
module hierarchical_tile_occupancy_map_top
    import hto_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [27:20] red_level, [35:28] alpha_level,
    // [41:36] cell_col, [47:42] cell_row
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [5:0] out_col, [11:6] out_row, [13:12] cell_class, [15:14] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [PIX_W:0]  PIX_LIM  = IMAGE_SIZE[PIX_W:0];
    localparam logic [CELL_W:0] CELL_LIM = CELLS[CELL_W:0];

    logic [MODE_W-1:0]  mode;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] alpha_level;
    logic [CELL_W-1:0]  cell_col;
    logic [CELL_W-1:0]  cell_row;
    logic [CELL_W-1:0]  pix_col;
    logic [CELL_W-1:0]  pix_row;
    logic [CELL_W-1:0]  sel_col;
    logic [CELL_W-1:0]  sel_row;
    logic               s_acc;
    logic               is_query;
    logic               pixel_set;
    logic               query_in_grid;
    logic               res_ready;
    t_store_req         store_req;
    logic [WORD_W-1:0]  block_word;

    logic               r_s1_valid;
    logic [CELL_W-1:0]  r_s1_col;
    logic [CELL_W-1:0]  r_s1_row;
    logic               r_s1_in_grid;

    assign mode        = s_axis_tuser;
    assign pixel_x     = s_axis_tdata[9:0];
    assign pixel_y     = s_axis_tdata[19:10];
    assign red_level   = s_axis_tdata[27:20];
    assign alpha_level = s_axis_tdata[35:28];
    assign cell_col    = s_axis_tdata[41:36];
    assign cell_row    = s_axis_tdata[47:42];

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign is_query = (mode == MODE_QUERY);

    assign pix_col = CELL_W'(pixel_x >> FINE_SHIFT);
    assign pix_row = CELL_W'(pixel_y >> FINE_SHIFT);

    assign pixel_set = (mode == MODE_PIXEL)
                    && ({1'b0, pixel_x} < PIX_LIM) && ({1'b0, pixel_y} < PIX_LIM)
                    && (red_level != '0) && (alpha_level == ALPHA_SOLID);

    assign query_in_grid = ({1'b0, cell_col} < CELL_LIM) && ({1'b0, cell_row} < CELL_LIM);

    assign sel_col = is_query ? cell_col : pix_col;
    assign sel_row = is_query ? cell_row : pix_row;

    always_comb begin
        store_req.wr_en   = s_acc && pixel_set;
        store_req.clr     = s_acc && (mode == MODE_CLEAR);
        store_req.rd_en   = s_acc && is_query;
        store_req.addr    = {sel_row[CELL_W-1:SUB_W], sel_col[CELL_W-1:SUB_W]};
        store_req.bit_idx = {sel_row[SUB_W-1:0], sel_col[SUB_W-1:0]};
    end

    assign s_axis_tready = !r_s1_valid || res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_acc && is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && is_query) begin
            r_s1_col     <= cell_col;
            r_s1_row     <= cell_row;
            r_s1_in_grid <= query_in_grid;
        end
    end

    hto_flag_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_word  (block_word)
    );

    hto_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s1_valid),
        .o_ready       (res_ready),
        .i_col         (r_s1_col),
        .i_row         (r_s1_row),
        .i_in_grid     (r_s1_in_grid),
        .i_word        (block_word),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_query_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_query) |=> r_s1_valid)
        else $error("accepted query did not reach the read stage");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !res_ready) |=> (r_s1_valid && $stable(r_s1_col)
                                        && $stable(r_s1_row)))
        else $error("stalled query lost or changed");

    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && !(s_acc && is_query)) |=> !r_s1_valid)
        else $error("read stage holds a query that was never accepted");

endmodule

// ===== src/hto_flag_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy flag store
// Solid flags kept as one 16-bit word per 4x4 block, with a valid bit per word
// so that a clear takes effect on every word at once.
// ----------------------------------------------------------------------------
module hto_flag_store
    import hto_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_req        i_req,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_row_valid;
    logic [WORD_W-1:0]    r_rd_word;
    logic                 r_rd_ok;
    logic [WORD_W-1:0]    onehot;
    logic [WORD_W-1:0]    wr_mask;
    logic [WORD_W-1:0]    wr_data;

    assign onehot = WORD_W'(1) << i_req.bit_idx;

    // A word that is not valid holds stale flags, so the first write rewrites all of it.
    always_comb begin
        if (r_row_valid[i_req.addr]) begin
            wr_mask = onehot;
            wr_data = '1;
        end else begin
            wr_mask = '1;
            wr_data = onehot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            for (int b = 0; b < WORD_W; b++) begin
                if (wr_mask[b]) begin
                    mem[i_req.addr][b] <= wr_data[b];
                end
            end
        end
        if (i_req.rd_en) begin
            r_rd_word <= mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_row_valid <= '0;
            end else if (i_req.wr_en) begin
                r_row_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_row_valid[i_req.addr];
            end
        end
    end

    assign o_word = r_rd_ok ? r_rd_word : '0;

    a_clear_all : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clr |=> (r_row_valid == '0))
        else $error("flag words still valid after a clear");

    a_write_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |=> r_row_valid[$past(i_req.addr)])
        else $error("written flag word not marked valid");

endmodule

// ===== src/hto_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy result stage
// Classifies a queried cell from its 4x4 block word and holds the result.
// ----------------------------------------------------------------------------
module hto_result
    import hto_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CELL_W-1:0]     i_col,
    input  logic [CELL_W-1:0]     i_row,
    input  logic                  i_in_grid,
    input  logic [WORD_W-1:0]     i_word,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [5:0] out_col, [11:6] out_row, [13:12] cell_class, [15:14] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                 r_out_valid;
    logic [CELL_W-1:0]    r_out_col;
    logic [CELL_W-1:0]    r_out_row;
    logic [CLASS_W-1:0]   r_out_class;
    logic [CLASS_W-1:0]   n_class;
    logic [BIT_W-1:0]     own_idx;
    logic [BIT_W-1:0]     quad_base;
    logic                 own_solid;
    logic                 quad_solid;
    logic                 block_solid;

    assign own_idx   = {i_row[SUB_W-1:0], i_col[SUB_W-1:0]};
    // Top-left flag of the 2x2 quadrant that holds the cell.
    assign quad_base = {i_row[1], 1'b0, i_col[1], 1'b0};

    assign own_solid   = i_word[own_idx];
    assign quad_solid  = i_word[quad_base] | i_word[quad_base + BIT_W'(1)]
                       | i_word[quad_base + BIT_W'(BLOCK_SPAN)]
                       | i_word[quad_base + BIT_W'(BLOCK_SPAN + 1)];
    assign block_solid = |i_word;

    always_comb begin
        priority if (!i_in_grid) begin
            n_class = CLASS_EMPTY;
        end else if (own_solid) begin
            n_class = CLASS_SOLID;
        end else if (quad_solid) begin
            n_class = CLASS_F16;
        end else if (block_solid) begin
            n_class = CLASS_F32;
        end else begin
            n_class = CLASS_EMPTY;
        end
    end

    assign o_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out_col   <= i_col;
            r_out_row   <= i_row;
            r_out_class <= n_class;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_class, r_out_row, r_out_col};

endmodule

// ===== verif/hierarchical_tile_occupancy_map_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical tile occupancy map testbench
// Streams pixel, query, clear and unused-mode transactions into the map and
// checks every query result against a shadow occupancy map kept here. Runs a
// directed part, then random traffic under changing input and output idling,
// a long output hold-off and full-rate stretches.
// ----------------------------------------------------------------------------
module hierarchical_tile_occupancy_map_top_tb
    import hto_pkg::*;
();

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 500;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] alpha;
        logic [CELL_W-1:0]  col;
        logic [CELL_W-1:0]  row;
    } t_map_item;

    typedef struct {
        logic [CELL_W-1:0]  col;
        logic [CELL_W-1:0]  row;
        logic [CLASS_W-1:0] cls;
    } t_cell_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [9:0] pixel_x, [19:10] pixel_y, [27:20] red_level, [35:28] alpha_level,
    // [41:36] cell_col, [47:42] cell_row
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] mode
    logic [MODE_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [5:0] out_col, [11:6] out_row, [13:12] cell_class, [15:14] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_map_item    pending_items[$];
    t_map_item    offered_item;
    t_cell_report expected_reports[$];
    logic         shadow_solid[CELLS][CELLS];  // [row][col]

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int fail_count = 0;

    hierarchical_tile_occupancy_map_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit block_has_solid(int col, int row, int span);
        int c0;
        int r0;
        c0 = col - (col % span);
        r0 = row - (row % span);
        for (int r = r0; r < r0 + span; r++) begin
            for (int c = c0; c < c0 + span; c++) begin
                if (r < CELLS && c < CELLS && shadow_solid[r][c]) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [CLASS_W-1:0] classify_cell(int col, int row);
        if (col >= CELLS || row >= CELLS) begin
            return CLASS_EMPTY;
        end
        if (shadow_solid[row][col]) begin
            return CLASS_SOLID;
        end
        if (block_has_solid(col, row, 2)) begin
            return CLASS_F16;
        end
        if (block_has_solid(col, row, 4)) begin
            return CLASS_F32;
        end
        return CLASS_EMPTY;
    endfunction

    task automatic clear_shadow_map();
        for (int r = 0; r < CELLS; r++) begin
            for (int c = 0; c < CELLS; c++) begin
                shadow_solid[r][c] = 1'b0;
            end
        end
    endtask

    // Updates the shadow map for one taken transaction and records the report
    // that a query must produce.
    task automatic apply_to_shadow_map(t_map_item it);
        t_cell_report rep;
        unique case (it.mode)
            MODE_PIXEL: begin
                if (it.px < IMAGE_SIZE && it.py < IMAGE_SIZE &&
                    it.red != 0 && it.alpha == ALPHA_SOLID) begin
                    shadow_solid[CELL_W'(it.py >> FINE_SHIFT)]
                                [CELL_W'(it.px >> FINE_SHIFT)] = 1'b1;
                end
            end
            MODE_QUERY: begin
                rep.col = it.col;
                rep.row = it.row;
                rep.cls = classify_cell(int'(it.col), int'(it.row));
                expected_reports = {expected_reports, rep};
            end
            MODE_CLEAR: begin
                clear_shadow_map();
            end
            default: begin
            end
        endcase
    endtask

    // Driver: keeps a transaction offered until it is taken, idles only between
    // transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_to_shadow_map(offered_item);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= offered_item.mode;
                    s_axis_tdata  <= {offered_item.row, offered_item.col,
                                      offered_item.alpha, offered_item.red,
                                      offered_item.py, offered_item.px};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result and paces the output ready.
    always @(posedge i_clk) begin
        t_cell_report want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result with nothing expected: data %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                if (m_axis_tdata[5:0] !== want.col) begin
                    $error("out_col expected %0d actual %0d", want.col, m_axis_tdata[5:0]);
                    fail_count++;
                end
                if (m_axis_tdata[11:6] !== want.row) begin
                    $error("out_row expected %0d actual %0d", want.row, m_axis_tdata[11:6]);
                    fail_count++;
                end
                if (m_axis_tdata[13:12] !== want.cls) begin
                    $error("cell_class expected %0d actual %0d", want.cls,
                           m_axis_tdata[13:12]);
                    fail_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_pixel(int x, int y, int red, int alpha);
        t_map_item it;
        it.mode  = MODE_PIXEL;
        it.px    = PIX_W'(x);
        it.py    = PIX_W'(y);
        it.red   = LEVEL_W'(red);
        it.alpha = LEVEL_W'(alpha);
        it.col   = CELL_W'($urandom);
        it.row   = CELL_W'($urandom);
        pending_items = {pending_items, it};
    endtask

    task automatic queue_query(int col, int row);
        t_map_item it;
        it.mode  = MODE_QUERY;
        it.px    = PIX_W'($urandom);
        it.py    = PIX_W'($urandom);
        it.red   = LEVEL_W'($urandom);
        it.alpha = LEVEL_W'($urandom);
        it.col   = CELL_W'(col);
        it.row   = CELL_W'(row);
        pending_items = {pending_items, it};
    endtask

    task automatic queue_fieldless(logic [MODE_W-1:0] mode);
        t_map_item it;
        it.mode  = mode;
        it.px    = PIX_W'($urandom);
        it.py    = PIX_W'($urandom);
        it.red   = LEVEL_W'($urandom);
        it.alpha = LEVEL_W'($urandom);
        it.col   = CELL_W'($urandom);
        it.row   = CELL_W'($urandom);
        pending_items = {pending_items, it};
    endtask

    // Random traffic centered on a wandering hot block, so that solid cells stay
    // sparse enough for all four classes to show up.
    task automatic queue_random_items(int count);
        int hot_col;
        int hot_row;
        int pick;
        int red;
        int alpha;
        hot_col = $urandom_range(CELLS - 1);
        hot_row = $urandom_range(CELLS - 1);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 5) begin
                hot_col = $urandom_range(CELLS - 1);
                hot_row = $urandom_range(CELLS - 1);
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                if ($urandom_range(99) < 35) begin
                    red   = $urandom_range(255, 1);
                    alpha = int'(ALPHA_SOLID);
                end else begin
                    red   = ($urandom_range(99) < 25) ? 0 : $urandom_range(255);
                    alpha = ($urandom_range(99) < 30) ? int'(ALPHA_SOLID)
                                                      : $urandom_range(254);
                    if (alpha == ALPHA_SOLID) begin
                        red = 0;
                    end
                end
                if ($urandom_range(99) < 70) begin
                    queue_pixel(((hot_col & ~3) * FINE_CELL) + $urandom_range(63),
                                ((hot_row & ~3) * FINE_CELL) + $urandom_range(63),
                                red, alpha);
                end else begin
                    queue_pixel($urandom_range(IMAGE_SIZE - 1),
                                $urandom_range(IMAGE_SIZE - 1), red, alpha);
                end
            end else if (pick < 93) begin
                if ($urandom_range(99) < 70) begin
                    queue_query((hot_col + $urandom_range(11) - 4) & (CELLS - 1),
                                (hot_row + $urandom_range(11) - 4) & (CELLS - 1));
                end else begin
                    queue_query($urandom_range(CELLS - 1), $urandom_range(CELLS - 1));
                end
            end else if (pick < 97) begin
                queue_fieldless(MODE_CLEAR);
            end else begin
                queue_fieldless(MODE_UNUSED);
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        clear_shadow_map();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 70;

        // Directed part: empty map, corner pixels, non-solid pixels, the three
        // hierarchy levels, the unused mode and a clear.
        queue_query(0, 0);
        queue_query(CELLS - 1, CELLS - 1);
        queue_pixel(0, 0, 255, int'(ALPHA_SOLID));
        queue_pixel(IMAGE_SIZE - 1, IMAGE_SIZE - 1, 1, int'(ALPHA_SOLID));
        queue_query(0, 0);
        queue_query(1, 1);
        queue_query(2, 2);
        queue_query(4, 4);
        queue_query(CELLS - 1, CELLS - 1);
        queue_query(CELLS - 2, CELLS - 2);
        queue_query(CELLS - 4, CELLS - 4);
        queue_pixel(10 * FINE_CELL, 10 * FINE_CELL, 0, int'(ALPHA_SOLID));
        queue_pixel(20 * FINE_CELL + 15, 20 * FINE_CELL + 15, 255, 254);
        queue_query(10, 10);
        queue_query(20, 20);
        queue_pixel(33 * FINE_CELL + 7, 5 * FINE_CELL + 9, 1, int'(ALPHA_SOLID));
        queue_query(32, 4);
        queue_query(34, 6);
        queue_fieldless(MODE_UNUSED);
        queue_query(33, 5);
        queue_fieldless(MODE_CLEAR);
        queue_query(0, 0);
        queue_query(33, 5);
        queue_query(CELLS - 1, CELLS - 1);
        wait_for_drain();

        queue_random_items(RANDOM_PER_PHASE);
        wait_for_drain();

        send_idle_pct = 70;
        recv_idle_pct = 20;
        queue_random_items(RANDOM_PER_PHASE);
        wait_for_drain();

        // Full rate, starting with a long output hold-off so the pipeline fills
        // and the input stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_asked++;
        queue_random_items(RANDOM_PER_PHASE);
        wait_for_drain();

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/hto_pkg.sv
src/hto_flag_store.sv
src/hto_result.sv
src/hierarchical_tile_occupancy_map_top.sv
verif/hierarchical_tile_occupancy_map_top_tb.sv
